// ===== sv/dda_line_point_generator_core_assert.svh =====
`ifndef DDA_LINE_POINT_GENERATOR_CORE_ASSERT_SVH
`define DDA_LINE_POINT_GENERATOR_CORE_ASSERT_SVH

// The checked property holds in the cycle after the antecedent.
`define DLPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// The checked property holds in the same cycle as the antecedent.
`define DLPG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/dlpg_pkg.sv =====
package dlpg_pkg;

  localparam int CoordBits   = 12;
  localparam int FracBitsDef = 16;

  localparam logic OpLoad    = 1'b0;
  localparam logic OpAdvance = 1'b1;

  typedef struct packed {
    logic                        opcode;
    logic signed [CoordBits-1:0] start_x;
    logic signed [CoordBits-1:0] start_y;
    logic signed [CoordBits-1:0] end_x;
    logic signed [CoordBits-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic                        last_point;
  } out_item_t;

endpackage

// ===== sv/dlpg_divider.sv =====
module dlpg_divider import dlpg_pkg::*; #(
  parameter int DIVIDEND_BITS = CoordBits + FracBitsDef,
  parameter int DIVISOR_BITS  = CoordBits
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DIVIDEND_BITS-1:0] dividend_i,
  input  logic [DIVISOR_BITS-1:0]  divisor_i,
  output logic                     done_o,
  output logic [DIVIDEND_BITS-1:0] quotient_o
);

  localparam int CntBits = $clog2(DIVIDEND_BITS + 1);

  logic [CntBits-1:0]       cnt_q;
  logic                     done_q;
  logic [DIVISOR_BITS-1:0]  rem_q;
  logic [DIVIDEND_BITS-1:0] quo_q;
  logic [DIVISOR_BITS-1:0]  div_q;
  logic [DIVISOR_BITS:0]    shifted;
  logic [DIVISOR_BITS:0]    diff;
  logic                     fits;

  // One restoring step: the dividend shifts out of the top of quo_q while
  // quotient bits shift in at the bottom.
  assign shifted = {rem_q, quo_q[DIVIDEND_BITS-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign fits    = !diff[DIVISOR_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntBits'(DIVIDEND_BITS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CntBits'(1);
      done_q <= (cnt_q == CntBits'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
      quo_q <= {quo_q[DIVIDEND_BITS-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== sv/dda_line_point_generator_core.sv =====
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o   in_item_i  (in_item_t)
// out      output     out_valid_o/out_stall_i out_item_o (out_item_t)
//
// An advance item with points left is taken and its point appears in the output
// register on the next cycle, so advance items can follow one per cycle while
// the output does not stall and no load is busy. A load item with distinct
// endpoints holds in_stall_o high while the shared restoring divider runs once
// per axis, one quotient bit per cycle. A zero-length load does not stall.
// Reset is asynchronous and leaves no line active. A stalled output holds
// its item and stalls the input side as well.
module dda_line_point_generator_core import dlpg_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int DivBits = CoordBits + FRAC_BITS;
  localparam int AccBits = DivBits + 1;
  localparam int IncBits = FRAC_BITS + 2;

  typedef enum logic [1:0] {
    StIdle,
    StStartX,
    StWaitX,
    StWaitY
  } state_e;

  state_e                   state_q;
  logic [CoordBits:0]       points_left_q;
  logic                     out_valid_q;
  out_item_t                out_item_q;

  logic signed [AccBits-1:0] acc_x_q, acc_y_q;
  logic signed [IncBits-1:0] inc_x_q, inc_y_q;
  logic [CoordBits-1:0]      ax_q, ay_q, step_q;
  logic                      neg_x_q, neg_y_q;

  logic                 in_acc, load_acc, adv_acc;
  logic [CoordBits:0]   dx, dy, dx_neg, dy_neg;
  logic [CoordBits-1:0] ax, ay, step;
  logic                 div_start, div_done;
  logic [DivBits-1:0]   div_dividend, div_quotient;
  logic [IncBits-1:0]   quo_ext, quo_neg;
  logic [CoordBits:0]   px_int, py_int;
  logic [CoordBits-1:0] px, py;

  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_acc   = in_acc && (in_item_i.opcode == OpLoad);
  assign adv_acc    = in_acc && (in_item_i.opcode == OpAdvance) && (points_left_q != '0);

  assign dx     = {in_item_i.end_x[CoordBits-1], in_item_i.end_x}
                - {in_item_i.start_x[CoordBits-1], in_item_i.start_x};
  assign dy     = {in_item_i.end_y[CoordBits-1], in_item_i.end_y}
                - {in_item_i.start_y[CoordBits-1], in_item_i.start_y};
  assign dx_neg = -dx;
  assign dy_neg = -dy;
  assign ax     = dx[CoordBits] ? dx_neg[CoordBits-1:0] : dx[CoordBits-1:0];
  assign ay     = dy[CoordBits] ? dy_neg[CoordBits-1:0] : dy[CoordBits-1:0];
  assign step   = (ax > ay) ? ax : ay;

  // The x division starts from its own state; the y division starts in the
  // cycle the x quotient comes back.
  assign div_start    = (state_q == StStartX) || ((state_q == StWaitX) && div_done);
  assign div_dividend = (state_q == StStartX) ? {ax_q, {FRAC_BITS{1'b0}}}
                                              : {ay_q, {FRAC_BITS{1'b0}}};

  dlpg_divider #(
    .DIVIDEND_BITS(DivBits),
    .DIVISOR_BITS (CoordBits)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (step_q),
    .done_o    (div_done),
    .quotient_o(div_quotient)
  );

  // The quotient never exceeds one whole unit, so FRAC_BITS+1 bits hold it.
  assign quo_ext = {1'b0, div_quotient[FRAC_BITS:0]};
  assign quo_neg = -quo_ext;

  // Truncation toward zero: a negative accumulator with a nonzero fraction
  // rounds its floor up by one.
  assign px_int = acc_x_q[AccBits-1:FRAC_BITS]
                + {{CoordBits{1'b0}}, acc_x_q[AccBits-1] && (|acc_x_q[FRAC_BITS-1:0])};
  assign py_int = acc_y_q[AccBits-1:FRAC_BITS]
                + {{CoordBits{1'b0}}, acc_y_q[AccBits-1] && (|acc_y_q[FRAC_BITS-1:0])};
  assign px     = px_int[CoordBits-1:0];
  assign py     = py_int[CoordBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      points_left_q <= '0;
      out_valid_q   <= 1'b0;
      out_item_q    <= '0;
    end else begin
      if (adv_acc) begin
        out_valid_q           <= 1'b1;
        out_item_q.point_x    <= px;
        out_item_q.point_y    <= py;
        out_item_q.last_point <= (points_left_q == (CoordBits+1)'(1));
        points_left_q         <= points_left_q - (CoordBits+1)'(1);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (load_acc) begin
            points_left_q <= {1'b0, step} + (CoordBits+1)'(1);
            state_q       <= (step == '0) ? StIdle : StStartX;
          end
        end
        StStartX: state_q <= StWaitX;
        StWaitX: begin
          if (div_done) begin
            state_q <= StWaitY;
          end
        end
        StWaitY: begin
          if (div_done) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      acc_x_q <= {in_item_i.start_x[CoordBits-1], in_item_i.start_x, {FRAC_BITS{1'b0}}};
      acc_y_q <= {in_item_i.start_y[CoordBits-1], in_item_i.start_y, {FRAC_BITS{1'b0}}};
      ax_q    <= ax;
      ay_q    <= ay;
      step_q  <= step;
      neg_x_q <= dx[CoordBits];
      neg_y_q <= dy[CoordBits];
      inc_x_q <= '0;
      inc_y_q <= '0;
    end else if (adv_acc) begin
      acc_x_q <= acc_x_q + {{(AccBits-IncBits){inc_x_q[IncBits-1]}}, inc_x_q};
      acc_y_q <= acc_y_q + {{(AccBits-IncBits){inc_y_q[IncBits-1]}}, inc_y_q};
    end
    if ((state_q == StWaitX) && div_done) begin
      inc_x_q <= neg_x_q ? quo_neg : quo_ext;
    end
    if ((state_q == StWaitY) && div_done) begin
      inc_y_q <= neg_y_q ? quo_neg : quo_ext;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== sv/dlpg_checker.sv =====
`include "dda_line_point_generator_core_assert.svh"

module dlpg_checker import dlpg_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  logic load_acc;
  logic load_long;
  logic out_held;

  assign load_acc  = in_valid_i && !in_stall_o && (in_item_i.opcode == OpLoad);
  // A load with distinct endpoints has to run the divider.
  assign load_long = load_acc && ((in_item_i.start_x != in_item_i.end_x)
                                  || (in_item_i.start_y != in_item_i.end_y));
  assign out_held  = out_valid_o && out_stall_i;

  `DLPG_ASSERT_NEXT(a_out_hold, out_held, out_valid_o, "output item dropped")
  `DLPG_ASSERT_NEXT(a_out_stable, out_held, $stable(out_item_o), "output item changed")
  `DLPG_ASSERT_NEXT(a_load_busy, load_long, in_stall_o, "no stall after load")
  `DLPG_ASSERT_NEXT(a_load_silent, load_acc && !out_valid_o, !out_valid_o, "load produced an item")

endmodule

bind dda_line_point_generator_core dlpg_checker u_dlpg_checker (.*);
